FILE: design/rmj_pkg.sv
// ----------------------------------------------------------------------------
// rmj_pkg: shared types and constants of the radar measurement Jacobian
// Widths, latencies and the payload types handed between pipeline parts.
// ----------------------------------------------------------------------------
package rmj_pkg;

  // Tolerance register
  localparam int          TOL_W         = 17;
  localparam logic [16:0] TOL_RESET     = 17'd66;
  localparam logic [0:0]  REG_MIN_COORD = 1'b0;

  // Quotient bits kept by each divider: 32 result bits and one overflow bit
  localparam int QW = 33;

  // Pipeline depths
  localparam int FRONT_LAT  = 3;
  localparam int SQRT_STEPS = 32;
  localparam int MUL_LAT    = 2;
  localparam int DIV_LAT    = QW + 2;
  localparam int PIPE_LEN   = FRONT_LAT + SQRT_STEPS + MUL_LAT + DIV_LAT;

  // Data carried alongside the square root chain
  typedef struct packed {
    logic [63:0] r2;
    logic [63:0] cmag;
    logic [31:0] mx;
    logic [31:0] my;
    logic        negx;
    logic        negy;
    logic        cneg;
  } side_t;

  // One result beat
  typedef struct packed {
    logic [31:0] range_by_x;
    logic [31:0] range_by_y;
    logic [31:0] bearing_by_x;
    logic [31:0] bearing_by_y;
    logic [31:0] rate_by_x;
    logic [31:0] rate_by_y;
  } res_t;

endpackage

FILE: design/rmj_sqrt_chain.sv
// ----------------------------------------------------------------------------
// rmj_sqrt_chain: integer square root as a row of cells
// Each cell settles one root bit from two radicand bits and passes the
// partial remainder, the partial root and a side payload to the next cell.
// ----------------------------------------------------------------------------
module rmj_sqrt_chain #(
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [63:0]   rad,
  input  logic [PW-1:0] side,
  output logic [31:0]   root,
  output logic [PW-1:0] side_out
);
  import rmj_pkg::*;

  localparam int N  = SQRT_STEPS;
  localparam int RW = 34;

  logic [RW-1:0] rem_q  [N];
  logic [31:0]   rt_q   [N];
  logic [63:0]   rd_q   [N];
  logic [PW-1:0] sd_q   [N];

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [RW-1:0] rem_i;
    logic [31:0]   rt_i;
    logic [63:0]   rd_i;
    logic [PW-1:0] sd_i;
    logic [RW+1:0] t;
    logic [RW+1:0] trial;
    logic [RW+1:0] diff;
    logic          ge;

    // The first cell starts from an empty remainder and root.
    if (k == 0) begin : g_first
      assign rem_i = '0;
      assign rt_i  = '0;
      assign rd_i  = rad;
      assign sd_i  = side;
    end else begin : g_next
      assign rem_i = rem_q[k-1];
      assign rt_i  = rt_q[k-1];
      assign rd_i  = rd_q[k-1];
      assign sd_i  = sd_q[k-1];
    end

    // Trial subtraction of 4*root+1 from the extended remainder.
    always_comb begin
      t     = {rem_i, rd_i[63:62]};
      trial = (RW+2)'({rt_i, 2'b01});
      ge    = (t >= trial);
      diff  = t - trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? diff[RW-1:0] : t[RW-1:0];
        rt_q[k]  <= {rt_i[30:0], ge};
        rd_q[k]  <= {rd_i[61:0], 2'b00};
        sd_q[k]  <= sd_i;
      end
    end
  end

  assign root     = rt_q[N-1];
  assign side_out = sd_q[N-1];

endmodule

FILE: design/rmj_div_chain.sv
// ----------------------------------------------------------------------------
// rmj_div_chain: restoring divider with a saturating signed result
// An entry stage checks for overflow, a row of cells settles one quotient
// bit each, and a final stage saturates and applies the sign.
// ----------------------------------------------------------------------------
module rmj_div_chain #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic          neg,
  output logic [31:0]   quo
);
  import rmj_pkg::*;

  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;
  logic          ovf_w;

  logic [DW-1:0] e_rem;
  logic [QW-1:0] e_bits;
  logic [DW-1:0] e_d;
  logic          e_neg;
  logic          e_ovf;

  logic [DW-1:0] c_rem  [QW];
  logic [QW-1:0] c_bits [QW];
  logic [QW-1:0] c_q    [QW];
  logic [DW-1:0] c_d    [QW];
  logic          c_neg  [QW];
  logic          c_ovf  [QW];

  // Overflow when the quotient would reach 2^33; otherwise the upper
  // numerator bits are already below the divisor and seed the remainder.
  always_comb begin
    hi_ext  = CW'(num[NW-1:QW]);
    den_ext = CW'(den);
    ovf_w   = (hi_ext >= den_ext);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_rem  <= ovf_w ? '0 : hi_ext[DW-1:0];
      e_bits <= num[QW-1:0];
      e_d    <= den;
      e_neg  <= neg;
      e_ovf  <= ovf_w;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_cell
    logic [DW-1:0] rem_i;
    logic [QW-1:0] bits_i;
    logic [QW-1:0] q_i;
    logic [DW-1:0] d_i;
    logic          neg_i;
    logic          ovf_i;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_i  = e_rem;
      assign bits_i = e_bits;
      assign q_i    = '0;
      assign d_i    = e_d;
      assign neg_i  = e_neg;
      assign ovf_i  = e_ovf;
    end else begin : g_next
      assign rem_i  = c_rem[k-1];
      assign bits_i = c_bits[k-1];
      assign q_i    = c_q[k-1];
      assign d_i    = c_d[k-1];
      assign neg_i  = c_neg[k-1];
      assign ovf_i  = c_ovf[k-1];
    end

    // Bring down the next numerator bit and subtract where it fits.
    always_comb begin
      t    = {rem_i, bits_i[QW-1]};
      ge   = (t >= {1'b0, d_i});
      diff = t - {1'b0, d_i};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_rem[k]  <= ge ? diff[DW-1:0] : t[DW-1:0];
        c_bits[k] <= {bits_i[QW-2:0], 1'b0};
        c_q[k]    <= {q_i[QW-2:0], ge};
        c_d[k]    <= d_i;
        c_neg[k]  <= neg_i;
        c_ovf[k]  <= ovf_i;
      end
    end
  end

  // Saturate to the signed 32-bit range and apply the sign.
  logic [QW-1:0] q_fin;
  logic [QW-1:0] limit;
  logic          sat;
  logic [31:0]   mag;

  always_comb begin
    q_fin = c_q[QW-1];
    limit = c_neg[QW-1] ? QW'(33'h080000000) : QW'(33'h07FFFFFFF);
    sat   = c_ovf[QW-1] || (q_fin > limit);
    mag   = sat ? limit[31:0] : q_fin[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= c_neg[QW-1] ? (32'd0 - mag) : mag;
    end
  end

endmodule

FILE: design/radar_measurement_jacobian_top.sv
// ----------------------------------------------------------------------------
// radar_measurement_jacobian_top: Jacobian of the polar radar measurement
// Clamps the position, forms the squared radius and cross term, takes the
// root in a chain of cells and runs six divider chains in parallel.
//
//   channel  direction  handshake                 payload
//   in       to block   in_valid / in_ready       pos_x pos_y vel_x vel_y
//   out      from block out_valid / out_ready     six Jacobian entries
//   cfg      to block   APB psel/penable/pwrite   min_coordinate
//
// One state vector is accepted every cycle while the output buffer has room; a result passes
// the front stages, the 32-cell root chain, the multiply stages and the 33-cell dividers.
// Reset clears all valid flags, the output buffer and sets the tolerance to 66.
// A two-slot output buffer absorbs back pressure; the whole pipeline holds only
// while both slots are full.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] range_by_x,
  output logic signed [31:0] range_by_y,
  output logic signed [31:0] bearing_by_x,
  output logic signed [31:0] bearing_by_y,
  output logic signed [31:0] rate_by_x,
  output logic signed [31:0] rate_by_y
);
  import rmj_pkg::*;

  localparam int SW = $bits(side_t);

  // Configuration register
  logic [TOL_W-1:0] min_coord;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2:2] == REG_MIN_COORD);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_coord <= TOL_RESET;
    end else if (wr_en) begin
      min_coord <= pwdata[TOL_W-1:0];
    end
  end

  assign prdata = (paddr[2:2] == REG_MIN_COORD) ? 32'(min_coord) : 32'd0;

  // Pipeline enable and valid flags
  logic [1:0]          count;
  logic                en;
  logic [PIPE_LEN-1:0] v;

  assign en       = (count != 2'd2);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[PIPE_LEN-2:0], in_valid};
    end
  end

  // Stage 1: tolerance and position clamp
  logic [TOL_W-1:0] tol;
  logic [31:0]      ax;
  logic [31:0]      ay;
  logic             clx;
  logic             cly;

  always_comb begin
    tol = (min_coord == '0) ? TOL_W'(1) : min_coord;
    ax  = pos_x[31] ? (32'd0 - pos_x) : pos_x;
    ay  = pos_y[31] ? (32'd0 - pos_y) : pos_y;
    clx = (ax < 32'(tol));
    cly = (ay < 32'(tol));
  end

  logic signed [31:0] s1_px;
  logic signed [31:0] s1_py;
  logic [31:0]        s1_mx;
  logic [31:0]        s1_my;
  logic signed [31:0] s1_vx;
  logic signed [31:0] s1_vy;
  logic [TOL_W-1:0]   s1_tol;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px  <= clx ? 32'(tol) : pos_x;
      s1_py  <= cly ? 32'(tol) : pos_y;
      s1_mx  <= clx ? 32'(tol) : ax;
      s1_my  <= cly ? 32'(tol) : ay;
      s1_vx  <= vel_x;
      s1_vy  <= vel_y;
      s1_tol <= tol;
    end
  end

  // Stage 2: squares, cross products and squared tolerance
  logic [63:0]        sqx_w;
  logic [63:0]        sqy_w;
  logic signed [63:0] a_w;
  logic signed [63:0] b_w;
  logic [33:0]        tol2_w;

  assign sqx_w  = s1_mx * s1_mx;
  assign sqy_w  = s1_my * s1_my;
  assign a_w    = s1_vx * s1_py;
  assign b_w    = s1_vy * s1_px;
  assign tol2_w = s1_tol * s1_tol;

  logic [63:0]        s2_sqx;
  logic [63:0]        s2_sqy;
  logic signed [63:0] s2_a;
  logic signed [63:0] s2_b;
  logic [33:0]        s2_tol2;
  logic [31:0]        s2_mx;
  logic [31:0]        s2_my;
  logic               s2_negx;
  logic               s2_negy;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sqx  <= sqx_w;
      s2_sqy  <= sqy_w;
      s2_a    <= a_w;
      s2_b    <= b_w;
      s2_tol2 <= tol2_w;
      s2_mx   <= s1_mx;
      s2_my   <= s1_my;
      s2_negx <= s1_px[31];
      s2_negy <= s1_py[31];
    end
  end

  // Stage 3: floored squared radius and cross term magnitude
  logic [63:0]        sum_w;
  logic signed [64:0] c_w;
  logic signed [64:0] cabs_w;

  always_comb begin
    sum_w  = s2_sqx + s2_sqy;
    c_w    = s2_a - s2_b;
    cabs_w = c_w[64] ? (65'sd0 - c_w) : c_w;
  end

  logic [63:0] s3_r2;
  side_t       s3_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r2        <= (sum_w < 64'(s2_tol2)) ? 64'(s2_tol2) : sum_w;
      s3_side.r2   <= (sum_w < 64'(s2_tol2)) ? 64'(s2_tol2) : sum_w;
      s3_side.cmag <= cabs_w[63:0];
      s3_side.mx   <= s2_mx;
      s3_side.my   <= s2_my;
      s3_side.negx <= s2_negx;
      s3_side.negy <= s2_negy;
      s3_side.cneg <= c_w[64];
    end
  end

  // Radius root chain
  logic [31:0]   root;
  logic [SW-1:0] side_vec;
  side_t         sq;

  rmj_sqrt_chain #(.PW(SW)) u_sqrt (
    .clk      (clk),
    .en       (en),
    .rad      (s3_r2),
    .side     (s3_side),
    .root     (root),
    .side_out (side_vec)
  );

  assign sq = side_t'(side_vec);

  // Multiply stage 1: 32 by 32 partial products
  logic [63:0] m1_rl, m1_rh, m1_yl, m1_yh, m1_xl, m1_xh;
  logic [63:0] m1_r2;
  logic [31:0] m1_root, m1_mx, m1_my;
  logic        m1_negx, m1_negy, m1_cneg;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_rl   <= root * sq.r2[31:0];
      m1_rh   <= root * sq.r2[63:32];
      m1_yl   <= sq.my * sq.cmag[31:0];
      m1_yh   <= sq.my * sq.cmag[63:32];
      m1_xl   <= sq.mx * sq.cmag[31:0];
      m1_xh   <= sq.mx * sq.cmag[63:32];
      m1_r2   <= sq.r2;
      m1_root <= root;
      m1_mx   <= sq.mx;
      m1_my   <= sq.my;
      m1_negx <= sq.negx;
      m1_negy <= sq.negy;
      m1_cneg <= sq.cneg;
    end
  end

  // Multiply stage 2: combine partial products
  logic [95:0] m2_den3, m2_ny, m2_nx;
  logic [63:0] m2_r2;
  logic [31:0] m2_root, m2_mx, m2_my;
  logic        m2_negx, m2_negy, m2_cneg;

  always_ff @(posedge clk) begin
    if (en) begin
      m2_den3 <= 96'(m1_rl) + {m1_rh, 32'd0};
      m2_ny   <= 96'(m1_yl) + {m1_yh, 32'd0};
      m2_nx   <= 96'(m1_xl) + {m1_xh, 32'd0};
      m2_r2   <= m1_r2;
      m2_root <= m1_root;
      m2_mx   <= m1_mx;
      m2_my   <= m1_my;
      m2_negx <= m1_negx;
      m2_negy <= m1_negy;
      m2_cneg <= m1_cneg;
    end
  end

  // Six divider chains
  res_t res_w;

  rmj_div_chain #(.NW(48), .DW(32)) u_div_rx (
    .clk (clk), .en (en), .num ({m2_mx, 16'd0}), .den (m2_root),
    .neg (m2_negx), .quo (res_w.range_by_x)
  );

  rmj_div_chain #(.NW(48), .DW(32)) u_div_ry (
    .clk (clk), .en (en), .num ({m2_my, 16'd0}), .den (m2_root),
    .neg (m2_negy), .quo (res_w.range_by_y)
  );

  rmj_div_chain #(.NW(64), .DW(64)) u_div_bx (
    .clk (clk), .en (en), .num ({m2_my, 32'd0}), .den (m2_r2),
    .neg (!m2_negy), .quo (res_w.bearing_by_x)
  );

  rmj_div_chain #(.NW(64), .DW(64)) u_div_by (
    .clk (clk), .en (en), .num ({m2_mx, 32'd0}), .den (m2_r2),
    .neg (m2_negx), .quo (res_w.bearing_by_y)
  );

  rmj_div_chain #(.NW(112), .DW(96)) u_div_tx (
    .clk (clk), .en (en), .num ({m2_ny, 16'd0}), .den (m2_den3),
    .neg (m2_negy ^ m2_cneg), .quo (res_w.rate_by_x)
  );

  rmj_div_chain #(.NW(112), .DW(96)) u_div_ty (
    .clk (clk), .en (en), .num ({m2_nx, 16'd0}), .den (m2_den3),
    .neg ((!m2_negx) ^ m2_cneg), .quo (res_w.rate_by_y)
  );

  // Two-slot output buffer
  res_t slot0;
  res_t slot1;
  logic push;
  logic pop;

  assign push = en && v[PIPE_LEN-1];
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= (push && (count == 2'd1)) ? res_w : slot1;
      if (push && (count == 2'd2)) begin
        slot1 <= res_w;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= res_w;
      end else begin
        slot1 <= res_w;
      end
    end
  end

  assign out_valid    = (count != 2'd0);
  assign range_by_x   = slot0.range_by_x;
  assign range_by_y   = slot0.range_by_y;
  assign bearing_by_x = slot0.bearing_by_x;
  assign bearing_by_y = slot0.bearing_by_y;
  assign rate_by_x    = slot0.rate_by_x;
  assign rate_by_y    = slot0.rate_by_y;

`ifndef ASSERT_OFF
  // A tolerance write lands in the register on the next cycle.
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (min_coord == $past(pwdata[TOL_W-1:0])))
    else $error("tolerance register not written");

  // The pipeline holds its valid flags while the buffer is full.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v))
    else $error("pipeline moved during stall");

  // A result pushed into the buffer is offered on the next cycle.
  a_push_shown: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("pushed result not offered");
`endif

endmodule

FILE: bench/jacobian_checker.sv
// ----------------------------------------------------------------------------
// jacobian_checker: scoreboard for the radar measurement Jacobian
// Watches the input, output and register channels, predicts the six Jacobian
// entries of every accepted state beat and compares them in order.
// ----------------------------------------------------------------------------
module jacobian_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] range_by_x,
  input  logic signed [31:0] range_by_y,
  input  logic signed [31:0] bearing_by_x,
  input  logic signed [31:0] bearing_by_y,
  input  logic signed [31:0] rate_by_x,
  input  logic signed [31:0] rate_by_y,
  output int                 failures,
  output int                 pending
);
  import rmj_pkg::*;

  logic [TOL_W-1:0] tolerance;
  res_t             jacobian_q[$];

  assign pending = jacobian_q.size();

  // Truncating quotient of magnitudes, signed and saturated to 32 bits.
  function automatic logic [31:0] sat_quotient(input logic neg, input logic [127:0] num,
                                               input logic [127:0] den);
    logic [127:0] q;
    logic [127:0] lim;
    q   = num / den;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) q = lim;
    return neg ? 32'(-q[31:0]) : q[31:0];
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      logic [63:0] t;
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic res_t jacobian_of(input logic signed [31:0] ix, input logic signed [31:0] iy,
                                       input logic signed [31:0] ivx, input logic signed [31:0] ivy);
    longint      px, py, tol, a, b;
    logic [63:0] mx, my, r2, r, cmag;
    logic        cneg;
    res_t        j;
    tol = (tolerance == 0) ? 1 : longint'(tolerance);
    px  = ix;
    py  = iy;
    if ((px < 0 ? -px : px) < tol) px = tol;
    if ((py < 0 ? -py : py) < tol) py = tol;
    mx  = px < 0 ? -px : px;
    my  = py < 0 ? -py : py;
    r2  = mx * mx + my * my;
    if (r2 < 64'(tol * tol)) r2 = tol * tol;
    r   = root_floor(r2);
    a   = longint'(ivx) * py;
    b   = longint'(ivy) * px;
    cneg = a < b;
    cmag = cneg ? 64'(b) - 64'(a) : 64'(a) - 64'(b);
    j.range_by_x   = sat_quotient(px < 0, 128'(mx) << 16, 128'(r));
    j.range_by_y   = sat_quotient(py < 0, 128'(my) << 16, 128'(r));
    j.bearing_by_x = sat_quotient(py > 0, 128'(my) << 32, 128'(r2));
    j.bearing_by_y = sat_quotient(px < 0, 128'(mx) << 32, 128'(r2));
    j.rate_by_x    = sat_quotient((py < 0) != cneg, (128'(my) * 128'(cmag)) << 16,
                                  128'(r2) * 128'(r));
    j.rate_by_y    = sat_quotient((px > 0) != cneg, (128'(mx) * 128'(cmag)) << 16,
                                  128'(r2) * 128'(r));
    return j;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    failures++;
  endtask

  // Follow the register, record expectations and compare result beats.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      tolerance <= TOL_RESET;
      failures  <= 0;
      jacobian_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2:2] == REG_MIN_COORD)
        tolerance <= pwdata[TOL_W-1:0];
      if (in_valid && in_ready)
        jacobian_q.push_back(jacobian_of(pos_x, pos_y, vel_x, vel_y));
      if (out_valid && out_ready) begin
        if (jacobian_q.size() == 0) begin
          report_mismatch("unexpected beat", range_by_x, 0);
        end else begin
          want = jacobian_q.pop_front();
          if (range_by_x != want.range_by_x)
            report_mismatch("range_by_x", range_by_x, want.range_by_x);
          if (range_by_y != want.range_by_y)
            report_mismatch("range_by_y", range_by_y, want.range_by_y);
          if (bearing_by_x != want.bearing_by_x)
            report_mismatch("bearing_by_x", bearing_by_x, want.bearing_by_x);
          if (bearing_by_y != want.bearing_by_y)
            report_mismatch("bearing_by_y", bearing_by_y, want.bearing_by_y);
          if (rate_by_x != want.rate_by_x)
            report_mismatch("rate_by_x", rate_by_x, want.rate_by_x);
          if (rate_by_y != want.rate_by_y)
            report_mismatch("rate_by_y", rate_by_y, want.rate_by_y);
        end
      end
    end
  end
endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus for the radar measurement Jacobian
// Writes the tolerance through its range, sends directed and random state
// beats under varying idle and stall patterns, and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import rmj_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic signed [31:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [31:0] range_by_x, range_by_y, bearing_by_x, bearing_by_y;
  logic signed [31:0] rate_by_x, rate_by_y;
  int failures, pending;
  int send_idle_pct = 0, stall_pct = 0;
  int hold_off = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  radar_measurement_jacobian_top u_top (.*);
  jacobian_checker u_chk (.*);

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off  <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_tolerance(input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {REG_MIN_COORD, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Random value biased towards extremes and small magnitudes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(400)) - 200);
      3: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return $urandom();
    endcase
  endfunction

  // Valid stays high between back-to-back beats and drops only for idle cycles.
  task automatic send_state(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] vx, input logic [31:0] vy);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= x; pos_y <= y; vel_x <= vx; vel_y <= vy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (PIPE_LEN + 10) @(posedge clk);
  endtask

  task automatic random_states(input int count);
    for (int i = 0; i < count; i++)
      send_state(pick_value(), pick_value(), pick_value(), pick_value());
  endtask

  initial begin
    logic [31:0] ext[6];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'd65};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, tiny positions and the reset tolerance.
    for (int i = 0; i < 6; i++) send_state(ext[i], ext[(i + 1) % 6], ext[(i + 2) % 6], ext[i]);
    send_state(32'sd65, -32'sd65, 32'h7FFF_FFFF, 32'h8000_0000);
    send_state(-32'sd66, 32'sd66, 32'h1, 32'hFFFF_FFFF);
    send_state(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
    send_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();

    // Zero tolerance, then the largest, with positions just below and at it.
    write_tolerance(32'd0);
    for (int i = 0; i < 6; i++) send_state(ext[i], ext[5 - i], ext[(i + 3) % 6], ext[i]);
    drain();
    write_tolerance(32'd131071);
    send_state(32'sd131070, -32'sd131070, 32'h7FFF_FFFF, 32'h8000_0000);
    send_state(32'sd131071, 32'sd5, 32'h1, 32'h1);
    drain();

    // Random phases over several tolerances and idle patterns.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      case (phase)
        0: write_tolerance(32'd1);
        2: write_tolerance(32'd65536);
        4: write_tolerance($urandom_range(65536, 1));
        6: write_tolerance(32'd66);
        default: ;
      endcase
      if (phase == 5) hold_off <= 300;
      random_states(100);
      drain();
    end

    if (failures == 0 && pending == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench NOT OK");
    $finish;
  end
endmodule
